/* design/min_max_stack_rejection_assert.svh */
// Assertion macros for the checker file.
`ifndef MIN_MAX_STACK_REJECTION_ASSERT_SVH
`define MIN_MAX_STACK_REJECTION_ASSERT_SVH

// Condition and consequence in the same cycle.
`define MMSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define MMSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mmsr_pkg.sv */
// Shared constants and types for the min/max stack rejection block.
`timescale 1ns / 1ps

package mmsr_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int VAL_W       = 16;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int ENTRY_W     = VAL_W + IDX_W;
  localparam int RAM_DEPTH   = 1 << IDX_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LOW   = 3'd0,
    CFG_CLIP_HIGH  = 3'd1,
    CFG_LOW_COUNT  = 3'd2,
    CFG_HIGH_COUNT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic clear;
    logic en;
  } rank_ctl_t;

endpackage

/* design/mmsr_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module mmsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/mmsr_rank.sv */
// Rank counter: counts stack entries ordered ahead of the pivot sample.
`timescale 1ns / 1ps

module mmsr_rank import mmsr_pkg::*; (
  input  logic             clk,
  input  rank_ctl_t        ctl,
  input  logic [VAL_W-1:0] pivot_value,
  input  logic [IDX_W-1:0] pivot_idx,
  input  logic [VAL_W-1:0] cand_value,
  input  logic [IDX_W-1:0] cand_idx,
  output logic [IDX_W-1:0] rank_total
);

  logic [IDX_W-1:0] count;
  logic             ahead;

  // stable order: equal values rank by arrival
  assign ahead = (cand_value < pivot_value) ||
                 ((cand_value == pivot_value) && (cand_idx < pivot_idx));

  assign rank_total = count + IDX_W'(ctl.en && ahead);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      count <= '0;
    end else if (ctl.en && ahead) begin
      count <= count + IDX_W'(1);
    end
  end

endmodule

/* design/min_max_stack_rejection.sv */
// Min/max rejection over one pixel stack: top level with sequencer.
// Each accepted sample is written to the store memory; after the closing sample
// the stack is ranked one sample at a time against every stored sample, then
// results leave in sorted order through the sort memory.
// A new stack is accepted once the last result of the previous one is loaded.
// Reset (rst, synchronous) clears the sequencer, fill count and output valid,
// and sets the registers to 1, 1, 1, 1; the memories are not cleared.
`timescale 1ns / 1ps

module min_max_stack_rejection import mmsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VAL_W-1:0]      sample_value,
  input  logic                  last_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VAL_W-1:0]      out_value,
  output logic [IDX_W-1:0]      frame_index,
  output logic                  low_rejected,
  output logic                  high_rejected,
  output logic [CNT_W-1:0]      kept_count,
  output logic                  last_result
);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_PIVOT,
    S_CAP,
    S_SWEEP,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t state;

  logic             clip_low;
  logic             clip_high;
  logic [CNT_W-1:0] low_cnt;
  logic [CNT_W-1:0] high_cnt;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] n_reg;
  logic [CNT_W-1:0] nl_reg;
  logic [CNT_W-1:0] nh_reg;
  logic [CNT_W-1:0] kept_reg;
  logic [IDX_W-1:0] i_idx;
  logic [CNT_W-1:0] j_cnt;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] k_idx;
  logic [VAL_W-1:0] pivot;

  logic             in_fire;
  logic             closing;
  logic [CNT_W-1:0] n_new;
  logic [CNT_W-1:0] nl_new;
  logic [CNT_W-1:0] nh_new;
  logic [CNT_W:0]   rej_sum;
  logic [CNT_W-1:0] kept_new;

  logic               store_re;
  logic [IDX_W-1:0]   store_raddr;
  logic [VAL_W-1:0]   store_rdata;
  logic               sort_we;
  logic               sort_re;
  logic [ENTRY_W-1:0] sort_rdata;
  logic [IDX_W-1:0]   rank_total;
  rank_ctl_t          rank_ctl;

  logic             load_out;
  logic [CNT_W-1:0] k_ext;
  logic             k_last;

  assign in_ready = (state == S_COLLECT);
  assign in_fire  = in_valid && in_ready;
  assign n_new    = fill + CNT_W'(1);
  assign closing  = last_sample || (n_new == CNT_W'(STACK_DEPTH));

  assign nl_new   = !clip_low  ? '0 : ((low_cnt  < n_new) ? low_cnt  : n_new);
  assign nh_new   = !clip_high ? '0 : ((high_cnt < n_new) ? high_cnt : n_new);
  assign rej_sum  = {1'b0, nl_new} + {1'b0, nh_new};
  assign kept_new = (rej_sum >= {1'b0, n_new}) ? '0 : (n_new - rej_sum[CNT_W-1:0]);

  always_comb begin
    store_raddr = i_idx;
    unique case (state)
      S_CAP:   store_raddr = '0;
      S_SWEEP: store_raddr = j_cnt[IDX_W-1:0];
      default: store_raddr = i_idx;
    endcase
  end

  assign store_re       = (state == S_PIVOT) || (state == S_CAP) || (state == S_SWEEP);
  assign rank_ctl.clear = (state == S_CAP);
  assign rank_ctl.en    = (state == S_SWEEP) || (state == S_PLACE);
  assign sort_we        = (state == S_PLACE);
  assign sort_re        = (state == S_EMIT_RD);

  assign load_out = (state == S_EMIT_LD) && (!out_valid || out_ready);
  assign k_ext    = CNT_W'(k_idx);
  assign k_last   = (k_ext + CNT_W'(1)) == n_reg;

  mmsr_ram #(
    .WIDTH(VAL_W),
    .DEPTH(RAM_DEPTH)
  ) u_store_ram (
    .clk  (clk),
    .we   (in_fire),
    .waddr(fill[IDX_W-1:0]),
    .wdata(sample_value),
    .re   (store_re),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  mmsr_rank u_rank (
    .clk        (clk),
    .ctl        (rank_ctl),
    .pivot_value(pivot),
    .pivot_idx  (i_idx),
    .cand_value (store_rdata),
    .cand_idx   (cmp_idx),
    .rank_total (rank_total)
  );

  mmsr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_sort_ram (
    .clk  (clk),
    .we   (sort_we),
    .waddr(rank_total),
    .wdata({pivot, i_idx}),
    .re   (sort_re),
    .raddr(k_idx),
    .rdata(sort_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_low  <= 1'b1;
      clip_high <= 1'b1;
      low_cnt   <= CNT_W'(1);
      high_cnt  <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CLIP_LOW:   clip_low  <= cfg_data[0];
        CFG_CLIP_HIGH:  clip_high <= cfg_data[0];
        CFG_LOW_COUNT:  low_cnt   <= cfg_data[CNT_W-1:0];
        CFG_HIGH_COUNT: high_cnt  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_COLLECT: begin
          if (in_fire) begin
            if (closing) begin
              fill     <= '0;
              n_reg    <= n_new;
              nl_reg   <= nl_new;
              nh_reg   <= nh_new;
              kept_reg <= kept_new;
              i_idx    <= '0;
              state    <= S_PIVOT;
            end else begin
              fill <= n_new;
            end
          end
        end
        S_PIVOT: begin
          state <= S_CAP;
        end
        S_CAP: begin
          pivot   <= store_rdata;
          j_cnt   <= CNT_W'(1);
          cmp_idx <= '0;
          state   <= (n_reg == CNT_W'(1)) ? S_PLACE : S_SWEEP;
        end
        S_SWEEP: begin
          j_cnt   <= j_cnt + CNT_W'(1);
          cmp_idx <= j_cnt[IDX_W-1:0];
          if (j_cnt == n_reg - CNT_W'(1)) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          if ((CNT_W'(i_idx) + CNT_W'(1)) == n_reg) begin
            k_idx <= '0;
            state <= S_EMIT_RD;
          end else begin
            i_idx <= i_idx + IDX_W'(1);
            state <= S_PIVOT;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (load_out) begin
            out_valid     <= 1'b1;
            out_value     <= sort_rdata[ENTRY_W-1:IDX_W];
            frame_index   <= sort_rdata[IDX_W-1:0];
            low_rejected  <= k_ext < nl_reg;
            high_rejected <= k_ext >= (n_reg - nh_reg);
            kept_count    <= kept_reg;
            last_result   <= k_last;
            k_idx         <= k_idx + IDX_W'(1);
            state         <= k_last ? S_COLLECT : S_EMIT_RD;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

endmodule

/* design/mmsr_checker.sv */
// Port-level checker for the min/max stack rejection block, bound to the top.
`timescale 1ns / 1ps
`include "min_max_stack_rejection_assert.svh"

module mmsr_checker import mmsr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VAL_W-1:0]      out_value,
  input logic                  low_rejected,
  input logic                  high_rejected,
  input logic [CNT_W-1:0]      kept_count,
  input logic                  last_result
);

  `MMSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "output transaction dropped or changed while stalled")
  `MMSR_ASSERT_SAME(a_both_flags, out_valid && low_rejected && high_rejected, kept_count == '0, "sample rejected on both sides while samples remain")
  `MMSR_ASSERT_SAME(a_kept_nonzero, out_valid && !low_rejected && !high_rejected, kept_count != '0, "kept sample reported with zero kept count")
  `MMSR_ASSERT_SAME(a_no_overlap, out_valid && !last_result, !in_ready, "input taken while a stack is still being emitted")

endmodule

bind min_max_stack_rejection mmsr_checker u_mmsr_checker (.*);

/* verif/testbench.sv */
// Testbench for min_max_stack_rejection: directed and random pixel stacks checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import mmsr_pkg::*;

  localparam int NUM_CFG_REGS   = 4;
  localparam int RANDOM_ITEMS   = 55;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {VALS_FULL, VALS_TIES, VALS_EXTREME} value_mix_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] frame;
    logic             low_rej;
    logic             high_rej;
    logic [CNT_W-1:0] kept;
    logic             last;
  } ranked_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VAL_W-1:0]      sample_value = '0;
  logic                  last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VAL_W-1:0]      out_value;
  logic [IDX_W-1:0]      frame_index;
  logic                  low_rejected;
  logic                  high_rejected;
  logic [CNT_W-1:0]      kept_count;
  logic                  last_result;

  // predictor state
  logic             clip_low;
  logic             clip_high;
  logic [CNT_W-1:0] low_cnt;
  logic [CNT_W-1:0] high_cnt;
  logic [VAL_W-1:0] open_vals[$];
  ranked_t          ranked_q[$];

  int  mismatches = 0;
  int  hold_req = 0;
  bit  no_gaps = 1'b0;
  int  stall_cycles = 0;

  min_max_stack_rejection uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_value(sample_value), .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_value), .frame_index(frame_index),
    .low_rejected(low_rejected), .high_rejected(high_rejected),
    .kept_count(kept_count), .last_result(last_result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CLIP_LOW:   clip_low = data[0];
      CFG_CLIP_HIGH:  clip_high = data[0];
      CFG_LOW_COUNT:  low_cnt = data[CNT_W-1:0];
      CFG_HIGH_COUNT: high_cnt = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Stable sort of the closed stack, then flag the nl lowest and nh highest.
  function automatic void rank_stack();
    logic [VAL_W-1:0] val [STACK_DEPTH];
    logic [IDX_W-1:0] pos [STACK_DEPTH];
    logic [VAL_W-1:0] kv;
    logic [IDX_W-1:0] kp;
    int n, nl, nh, kept, j;
    ranked_t r;
    n = open_vals.size();
    for (int i = 0; i < n; i++) begin
      val[i] = open_vals[i];
      pos[i] = i[IDX_W-1:0];
    end
    for (int i = 1; i < n; i++) begin
      kv = val[i];
      kp = pos[i];
      j = i;
      while (j > 0 && val[j-1] > kv) begin
        val[j] = val[j-1];
        pos[j] = pos[j-1];
        j--;
      end
      val[j] = kv;
      pos[j] = kp;
    end
    nl = clip_low ? ((int'(low_cnt) < n) ? int'(low_cnt) : n) : 0;
    nh = clip_high ? ((int'(high_cnt) < n) ? int'(high_cnt) : n) : 0;
    kept = n - (((nl + nh) < n) ? (nl + nh) : n);
    for (int k = 0; k < n; k++) begin
      r.value = val[k];
      r.frame = pos[k];
      r.low_rej = (k < nl);
      r.high_rej = (k >= n - nh);
      r.kept = kept[CNT_W-1:0];
      r.last = (k == n - 1);
      ranked_q.push_back(r);
    end
    open_vals.delete();
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays up across back-to-back transactions; lowered only for a gap
  task automatic send_sample(input logic [VAL_W-1:0] v, input logic l);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_value <= v;
    last_sample <= l;
    do @(posedge clk); while (!in_ready);
    open_vals.push_back(v);
    if (l || open_vals.size() == STACK_DEPTH) rank_stack();
  endtask

  function automatic logic [VAL_W-1:0] pick_value(input value_mix_t mix);
    case (mix)
      VALS_TIES:    return VAL_W'($urandom_range(0, 3));
      VALS_EXTREME: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default:      return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_DATA_W'(STACK_DEPTH);
      2:       return '1;
      default: return CFG_DATA_W'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic send_stack(input int n, input value_mix_t mix);
    for (int i = 0; i < n; i++) send_sample(pick_value(mix), i == n - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ranked_q.size() != 0 || hold_req != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h1234, 1'b1);
    drain();
  endtask

  task automatic test_ties();
    send_sample(16'd7, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd7, 1'b1);
    drain();
  endtask

  task automatic test_both_disabled();
    // upper data bits set, bit 0 clear: the enables must drop
    write_reg(CFG_CLIP_LOW, 7'h7E);
    write_reg(CFG_CLIP_HIGH, 7'h7E);
    send_sample(16'd100, 1'b0);
    send_sample(16'd50, 1'b0);
    send_sample(16'd50, 1'b0);
    send_sample(16'd200, 1'b1);
    drain();
  endtask

  task automatic test_overlap();
    write_reg(CFG_CLIP_LOW, 7'h01);
    write_reg(CFG_CLIP_HIGH, 7'h7F);
    write_reg(CFG_LOW_COUNT, 7'd3);
    write_reg(CFG_HIGH_COUNT, 7'd4);
    send_stack(5, VALS_FULL);
    drain();
  endtask

  task automatic test_count_extremes();
    write_reg(CFG_LOW_COUNT, '0);
    write_reg(CFG_HIGH_COUNT, '0);
    send_stack(2, VALS_EXTREME);
    drain();
    write_reg(CFG_LOW_COUNT, CFG_DATA_W'(STACK_DEPTH));
    write_reg(CFG_HIGH_COUNT, '1);
    send_stack(3, VALS_FULL);
    drain();
  endtask

  task automatic test_unused_index();
    logic [CFG_IDX_W-1:0] idx;
    for (int i = NUM_CFG_REGS; i < (1 << CFG_IDX_W); i++) begin
      idx = i[CFG_IDX_W-1:0];
      write_reg(idx, CFG_DATA_W'($urandom_range(0, 127)));
    end
    send_stack(2, VALS_FULL);
    drain();
  endtask

  task automatic test_store_full();
    write_reg(CFG_LOW_COUNT, 7'd7);
    write_reg(CFG_HIGH_COUNT, 7'd9);
    // stack closes on depth alone unless the 64th sample happens to carry last
    for (int i = 0; i < STACK_DEPTH; i++)
      send_sample(pick_value(VALS_FULL),
                  (i == STACK_DEPTH - 1) && ($urandom_range(0, 1) != 0));
    drain();
  endtask

  task automatic test_random_stacks();
    int sent, n;
    value_mix_t mix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_reg(CFG_CLIP_LOW, CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(CFG_CLIP_HIGH, CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(CFG_LOW_COUNT, pick_count());
        write_reg(CFG_HIGH_COUNT, pick_count());
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      mix = value_mix_t'($urandom_range(0, 2));
      send_stack(n, mix);
      sent += n;
    end
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_output_hold();
    write_reg(CFG_LOW_COUNT, 7'd2);
    write_reg(CFG_HIGH_COUNT, 7'd1);
    no_gaps = 1'b1;
    hold_req = HOLD_CYCLES;
    send_stack(6, VALS_FULL);
    send_stack(6, VALS_TIES);
    no_gaps = 1'b0;
    drain();
  endtask

  // result side: random stalls, long hold on request, compare with oldest prediction
  initial begin
    int stall;
    ranked_t want;
    wait (!rst);
    forever begin
      if (hold_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (ranked_q.size() == 0) begin
        $error("unexpected result transaction: out_value %0d", out_value);
        mismatches++;
      end else begin
        want = ranked_q.pop_front();
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, actual %0d", want.value, out_value);
          mismatches++;
        end
        if (frame_index !== want.frame) begin
          $error("frame_index: expected %0d, actual %0d", want.frame, frame_index);
          mismatches++;
        end
        if (low_rejected !== want.low_rej) begin
          $error("low_rejected: expected %0d, actual %0d", want.low_rej, low_rejected);
          mismatches++;
        end
        if (high_rejected !== want.high_rej) begin
          $error("high_rejected: expected %0d, actual %0d", want.high_rej, high_rejected);
          mismatches++;
        end
        if (kept_count !== want.kept) begin
          $error("kept_count: expected %0d, actual %0d", want.kept, kept_count);
          mismatches++;
        end
        if (last_result !== want.last) begin
          $error("last_result: expected %0d, actual %0d", want.last, last_result);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clip_low = 1'b1;
    clip_high = 1'b1;
    low_cnt = 7'd1;
    high_cnt = 7'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_ties();
    test_both_disabled();
    test_overlap();
    test_count_extremes();
    test_unused_index();
    test_store_full();
    test_random_stacks();
    test_output_hold();
    if (mismatches == 0 && ranked_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* min_max_stack_rejection.f */
+incdir+design
design/mmsr_pkg.sv
design/mmsr_ram.sv
design/mmsr_rank.sv
design/min_max_stack_rejection.sv
design/mmsr_checker.sv
verif/testbench.sv
